@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the WAV duration parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define WDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/wdp_pkg.sv @@
// Types and constants of the WAV duration parser.
package wdp_pkg;

  // Tags as they appear on the wire, first byte in bits 7:0.
  localparam logic [31:0] RiffTag = 32'h4646_4952;
  localparam logic [31:0] WaveTag = 32'h4556_4157;
  localparam logic [31:0] IdFmt   = 32'h2074_6D66;
  localparam logic [31:0] IdData  = 32'h6174_6164;

  localparam int HdrLen      = 12;
  localparam int ChunkHdrLen = 8;
  localparam int FmtMin      = 16;
  localparam int RateFirst   = 8;
  localparam int RateLast    = 11;

  localparam int            MilliW = 10;
  localparam logic [MilliW-1:0] Milli = MilliW'(1000);
  localparam int            MulW   = 32 + MilliW;
  localparam int            DivSteps = MulW;
  localparam int            CntW   = $clog2(DivSteps);

  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_FMT,
    PH_SKIP,
    PH_FAILED
  } phase_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_STEP,
    DV_HOLD
  } div_state_t;

  // One finished file handed from the parser to the divider.
  typedef struct packed {
    logic        ok;
    logic [31:0] size;
    logic [31:0] rate;
  } job_t;

endpackage

@@ hw/rtl/wdp_if.sv @@
// Valid/ready channel interfaces for the byte input and the duration result.
interface wdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] duration_ms;

  modport source (output valid, output duration_ms, input ready);
  modport sink   (input valid, input duration_ms, output ready);
endinterface

@@ hw/rtl/wdp_front.sv @@
// Byte parser: walks the RIFF header and chunks, posts one job per file.
module wdp_front import wdp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       push,
  output job_t       job
);

  phase_t       phase_r, phase_nxt, step_phase;
  logic [3:0]   idx_r, idx_nxt;
  logic [55:0]  chunk_r, chunk_nxt;
  logic [32:0]  skip_r, skip_nxt;
  logic [31:0]  fmt_len_r, fmt_len_nxt;
  logic [31:0]  rate_r, rate_nxt, rate_step;
  logic [31:0]  size_r, size_nxt, size_step;

  logic         tag_bad;
  logic [31:0]  hdr_id;
  logic [31:0]  hdr_size;
  logic [32:0]  hdr_padded;
  logic [32:0]  fmt_skip;
  logic         hdr_done;
  logic         fmt_done;

  assign hdr_id     = chunk_r[31:0];
  assign hdr_size   = {data_byte, chunk_r[55:32]};
  assign hdr_padded = {1'b0, hdr_size} + 33'(hdr_size[0]);
  assign fmt_skip   = {1'b0, fmt_len_r - 32'(FmtMin)} + 33'(fmt_len_r[0]);
  assign hdr_done   = (idx_r == 4'(ChunkHdrLen - 1));
  assign fmt_done   = (idx_r == 4'(FmtMin - 1));

  always_comb begin
    tag_bad = 1'b0;
    if (idx_r < 4'd4) begin
      tag_bad = (data_byte != RiffTag[{idx_r[1:0], 3'b000} +: 8]);
    end else if (idx_r >= 4'd8) begin
      tag_bad = (data_byte != WaveTag[{idx_r[1:0], 3'b000} +: 8]);
    end
  end

  // Next phase for this beat, before the end-of-file return to header.
  always_comb begin
    step_phase = phase_r;
    case (phase_r)
      PH_HEADER: begin
        if (tag_bad) begin
          step_phase = PH_FAILED;
        end else if (idx_r == 4'(HdrLen - 1)) begin
          step_phase = PH_CHUNK;
        end
      end
      PH_CHUNK: begin
        if (hdr_done) begin
          if (hdr_id == IdFmt) begin
            step_phase = (hdr_size < 32'(FmtMin)) ? PH_FAILED : PH_FMT;
          end else begin
            step_phase = (hdr_padded == '0) ? PH_CHUNK : PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        if (fmt_done) begin
          step_phase = (fmt_skip == '0) ? PH_CHUNK : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip_r == 33'd1) begin
          step_phase = PH_CHUNK;
        end
      end
      default: step_phase = phase_r;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      phase_nxt = last_byte ? PH_HEADER : step_phase;
    end
  end

  always_comb begin
    idx_nxt     = idx_r;
    chunk_nxt   = chunk_r;
    skip_nxt    = skip_r;
    fmt_len_nxt = fmt_len_r;
    rate_step   = rate_r;
    size_step   = size_r;
    case (phase_r)
      PH_HEADER: begin
        idx_nxt = (idx_r == 4'(HdrLen - 1)) ? 4'd0 : idx_r + 4'd1;
      end
      PH_CHUNK: begin
        if (hdr_done) begin
          idx_nxt = 4'd0;
          if (hdr_id == IdFmt) begin
            fmt_len_nxt = hdr_size;
          end else begin
            if (hdr_id == IdData) begin
              size_step = hdr_size;
            end
            skip_nxt = hdr_padded;
          end
        end else begin
          chunk_nxt[{idx_r[2:0], 3'b000} +: 8] = data_byte;
          idx_nxt = idx_r + 4'd1;
        end
      end
      PH_FMT: begin
        if (idx_r >= 4'(RateFirst) && idx_r <= 4'(RateLast)) begin
          rate_step[{idx_r[1:0], 3'b000} +: 8] = data_byte;
        end
        idx_nxt = idx_r + 4'd1;
        if (fmt_done) begin
          skip_nxt = fmt_skip;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_r - 33'd1;
      end
      default: idx_nxt = idx_r;
    endcase
    rate_nxt = rate_step;
    size_nxt = size_step;
    if (last_byte) begin
      idx_nxt     = '0;
      skip_nxt    = '0;
      fmt_len_nxt = '0;
      rate_nxt    = '0;
      size_nxt    = '0;
    end
  end

  assign push     = in_fire && last_byte;
  assign job.ok   = (step_phase == PH_CHUNK || step_phase == PH_SKIP) &&
                    (rate_step != '0) && (size_step != '0);
  assign job.size = size_step;
  assign job.rate = rate_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      idx_r     <= '0;
      chunk_r   <= '0;
      skip_r    <= '0;
      fmt_len_r <= '0;
      rate_r    <= '0;
      size_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (in_fire) begin
        idx_r     <= idx_nxt;
        chunk_r   <= chunk_nxt;
        skip_r    <= skip_nxt;
        fmt_len_r <= fmt_len_nxt;
        rate_r    <= rate_nxt;
        size_r    <= size_nxt;
      end
    end
  end

endmodule

@@ hw/rtl/wdp_queue.sv @@
// Small job queue between the parser and the divider.
module wdp_queue import wdp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t             mem_r [QueueDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPtrW + 1)'(QueueDepth));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QPtrW'(QueueDepth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == QPtrW'(QueueDepth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/wdp_div.sv @@
// Back end: size*1000 then a bit-serial restoring divide by the byte rate.
module wdp_div import wdp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  job_t        head,
  input  logic        q_empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_data
);

  div_state_t       state_r, state_nxt;
  logic [31:0]      size_r, size_nxt;
  logic [31:0]      rate_r, rate_nxt;
  logic [MulW-1:0]  num_r, num_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             ov_r, ov_nxt;
  logic [31:0]      od_r, od_nxt;

  logic [32:0]      rem_sh;
  logic             q_bit;
  logic             out_free;

  assign out_free = !ov_r || out_ready;
  assign rem_sh   = {rem_r, num_r[MulW-1]};
  assign q_bit    = (rem_sh >= {1'b0, rate_r});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DV_IDLE: begin
        if (!q_empty) begin
          state_nxt = head.ok ? DV_MUL : DV_HOLD;
        end
      end
      DV_MUL:  state_nxt = DV_STEP;
      DV_STEP: begin
        if (cnt_r == '0) begin
          state_nxt = DV_HOLD;
        end
      end
      DV_HOLD: begin
        if (out_free) begin
          state_nxt = DV_IDLE;
        end
      end
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    size_nxt = size_r;
    rate_nxt = rate_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = ov_r && !out_ready;
    od_nxt   = od_r;
    case (state_r)
      DV_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          size_nxt = head.size;
          rate_nxt = head.rate;
          num_nxt  = '0;   // an invalid file leaves a zero quotient
        end
      end
      DV_MUL: begin
        num_nxt = MulW'(size_r) * MulW'(Milli);
        rem_nxt = '0;
        cnt_nxt = CntW'(DivSteps - 1);
      end
      DV_STEP: begin
        rem_nxt = q_bit ? 32'(rem_sh - {1'b0, rate_r}) : rem_sh[31:0];
        num_nxt = {num_r[MulW-2:0], q_bit};
        cnt_nxt = cnt_r - 1'b1;
      end
      DV_HOLD: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = num_r[31:0];
        end
      end
      default: pop = 1'b0;
    endcase
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    size_r <= size_nxt;
    rate_r <= rate_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    od_r   <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

@@ hw/rtl/wav_duration_parser.sv @@
// WAV duration parser, top level.
// Takes a WAV file one byte per beat (last_byte on the final beat) and returns
// one 32-bit duration in milliseconds per file: data size * 1000 / byte rate,
// or 0 for a bad RIFF/WAVE tag, a fmt chunk under 16 bytes, a file that ends in
// the 12-byte header or the first 16 bytes of a fmt body, or a missing rate or
// size. The parser takes a byte every cycle while the queue has room; at the final
// byte it posts the file's size and rate into a two-entry queue. A divider behind
// it loads a valid file, multiplies, runs 42 restoring divide steps and writes
// the output register; an invalid file goes from the load straight to the output
// write. The byte input stalls only while the queue holds two files not yet
// started.
`include "assert_macros.svh"

module wav_duration_parser import wdp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  wdp_in_if.sink     in_bus,
  wdp_out_if.source  out_bus
);

  logic in_fire;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t new_job;
  job_t head_job;

  assign in_bus.ready = !q_full;
  assign in_fire      = in_bus.valid && in_bus.ready;

  wdp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_bus.data_byte),
    .last_byte (in_bus.last_byte),
    .push      (q_push),
    .job       (new_job)
  );

  wdp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (new_job),
    .pop    (q_pop),
    .head   (head_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  wdp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_job),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_data  (out_bus.duration_ms)
  );

  `WDP_ASSERT_NOW(a_no_push_full, q_push, !q_full, "job pushed into a full queue")
  `WDP_ASSERT_NOW(a_no_pop_empty, q_pop, !q_empty, "job popped from an empty queue")
  `WDP_ASSERT_NEXT(a_push_lands, q_push, !q_empty, "pushed job missing from queue")

endmodule
